// ===== hdl/fees_pkg.sv =====
// fees_pkg: word types, field widths and register/op codes of the elastic energy stencil
// used by the top level and the testbench; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fees_pkg;

  localparam int COORD_W   = 5;
  localparam int DIR_W     = 16;
  localparam int ENERGY_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int SITE_W    = 3 * DIR_W;

  // ops
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAD_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIRALITY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLAY_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TWIST_WEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BEND_WEIGHT  = 3'd6;

  typedef struct packed {
    logic                    op;
    logic [COORD_W-1:0]      site_x;
    logic [COORD_W-1:0]      site_y;
    logic [COORD_W-1:0]      site_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] splay_energy;
    logic [ENERGY_W-1:0] twist_energy;
    logic [ENERGY_W-1:0] bend_energy;
    logic                saturated;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/fees_ram.sv =====
// fees_ram: generic single-port synchronous ram, one read or write per cycle
// read data registered; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fees_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/frank_elastic_energy_stencil_unit.sv =====
// frank_elastic_energy_stencil_unit: top level of the elastic energy stencil
// uses fees_pkg (word types, codes) and fees_ram (director store)
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake             word
// -------   ---  --------------------  -------------------------------------
// in_       in   in_valid / in_stall   fees_pkg::in_word_t (op, site, dir)
// out_      out  out_valid / out_stall fees_pkg::out_word_t (energies, sat)
// cfg_      in   cfg_valid / cfg_ready cfg_index (3 bits), cfg_data (32 bits)
//
// a write word: the store is written in the cycle it is taken
// an eval word reads the centre and six neighbours through the single store
// port, makes three passes of the shared axis unit, then works out curl,
// twist/bend, squares and weighting
// reset is synchronous; the director store has no reset and is not cleared
// a finished result waits in the output register while the next word is taken;
// a second result stalls in the last step until that register frees up

module frank_elastic_energy_stencil_unit #(
  parameter int SIZE_X = 32,
  parameter int SIZE_Y = 32,
  parameter int SIZE_Z = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire fees_pkg::in_word_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output fees_pkg::out_word_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fees_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fees_pkg::CFG_W-1:0]          cfg_data
);

  localparam int XW = $clog2(SIZE_X);
  localparam int YW = $clog2(SIZE_Y);
  localparam int ZW = $clog2(SIZE_Z);
  localparam int AW = XW + YW + ZW;
  localparam int NCOORD = 2 ** fees_pkg::COORD_W;
  localparam int DW = fees_pkg::DIR_W;

  // datapath widths
  localparam int DOT_W  = 34;          // dot product of two directors
  localparam int PD_W   = DOT_W + DW;  // dot times component
  localparam int DD_W   = PD_W + 1;    // weighted neighbour difference
  localparam int DQ_W   = DD_W - 22;   // difference rounded to q.20
  localparam int GP_W   = DQ_W + 33;   // times gradient
  localparam int DN_W   = GP_W - 20;   // derivative, q.16
  localparam int CU_W   = DN_W + 1;    // curl terms
  localparam int SP_W   = DN_W + 2;    // splay sum
  localparam int TP_W   = DW + CU_W;   // director times curl term
  localparam int RAW_W  = TP_W + 2;
  localparam int BD_W   = RAW_W - 14;
  localparam int TW_W   = BD_W + 1;
  localparam int MG_W   = 48;
  localparam int EW     = fees_pkg::ENERGY_W;

  // read slots of an evaluation
  localparam logic [2:0] RD_CEN  = 3'd0;
  localparam logic [2:0] RD_XP   = 3'd1;
  localparam logic [2:0] RD_XM   = 3'd2;
  localparam logic [2:0] RD_YP   = 3'd3;
  localparam logic [2:0] RD_YM   = 3'd4;
  localparam logic [2:0] RD_ZP   = 3'd5;
  localparam logic [2:0] RD_ZM   = 3'd6;
  localparam logic [2:0] RD_DONE = 3'd7;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_READ = 13'b0000000000010,
    ST_DOT  = 13'b0000000000100,
    ST_DIF  = 13'b0000000001000,
    ST_GRD  = 13'b0000000010000,
    ST_CRL  = 13'b0000000100000,
    ST_TWB  = 13'b0000001000000,
    ST_RND  = 13'b0000010000000,
    ST_MAG  = 13'b0000100000000,
    ST_SQR  = 13'b0001000000000,
    ST_SUM  = 13'b0010000000000,
    ST_ENG  = 13'b0100000000000,
    ST_FIN  = 13'b1000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       out_valid_r, out_valid_nxt;

  // configuration registers
  logic [31:0]        grad_x_r, grad_y_r;
  logic [30:0]        grad_z_r;
  logic signed [31:0] chirality_r;
  logic [31:0]        splay_weight_r, twist_weight_r, bend_weight_r;

  // site coordinates of the word being evaluated
  logic [XW-1:0] xr_r;
  logic [YW-1:0] yr_r;
  logic [ZW-1:0] zr_r;
  logic          z_end_r;

  // coordinate reduction tables (site field modulo lattice size)
  logic [XW-1:0] xmod_tbl [NCOORD];
  logic [YW-1:0] ymod_tbl [NCOORD];
  logic [ZW-1:0] zmod_tbl [NCOORD];

  for (genvar i = 0; i < NCOORD; i++) begin : g_mod
    assign xmod_tbl[i] = XW'(i % SIZE_X);
    assign ymod_tbl[i] = YW'(i % SIZE_Y);
    assign zmod_tbl[i] = ZW'(i % SIZE_Z);
  end

  logic [XW-1:0] xin, xp, xm;
  logic [YW-1:0] yin, yp, ym;
  logic [ZW-1:0] zin, zp, zm;

  assign xin = xmod_tbl[in_data.site_x];
  assign yin = ymod_tbl[in_data.site_y];
  assign zin = zmod_tbl[in_data.site_z];

  // periodic in x and y
  assign xp = (xr_r == XW'(SIZE_X - 1)) ? '0 : XW'(xr_r + XW'(1));
  assign xm = (xr_r == '0) ? XW'(SIZE_X - 1) : XW'(xr_r - XW'(1));
  assign yp = (yr_r == YW'(SIZE_Y - 1)) ? '0 : YW'(yr_r + YW'(1));
  assign ym = (yr_r == '0) ? YW'(SIZE_Y - 1) : YW'(yr_r - YW'(1));

  // one-sided at the z end planes, the site itself stands in for the missing one
  always_comb begin
    if (zr_r == '0) begin
      zp = ZW'(1);
      zm = zr_r;
    end else if (zr_r == ZW'(SIZE_Z - 1)) begin
      zp = zr_r;
      zm = ZW'(SIZE_Z - 2);
    end else begin
      zp = ZW'(zr_r + ZW'(1));
      zm = ZW'(zr_r - ZW'(1));
    end
  end

  // director store
  logic                            in_acc;
  logic                            ram_we;
  logic [AW-1:0]                   ram_addr, rd_addr;
  logic [fees_pkg::SITE_W-1:0]     ram_rdata;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ram_we   = in_acc && (in_data.op == fees_pkg::OP_WRITE);

  always_comb begin
    case (cnt_r)
      RD_CEN:  rd_addr = {zr_r, yr_r, xr_r};
      RD_XP:   rd_addr = {zr_r, yr_r, xp};
      RD_XM:   rd_addr = {zr_r, yr_r, xm};
      RD_YP:   rd_addr = {zr_r, yp, xr_r};
      RD_YM:   rd_addr = {zr_r, ym, xr_r};
      RD_ZP:   rd_addr = {zp, yr_r, xr_r};
      RD_ZM:   rd_addr = {zm, yr_r, xr_r};
      default: rd_addr = {zr_r, yr_r, xr_r};
    endcase
  end

  assign ram_addr = (state_r == ST_IDLE) ? {zin, yin, xin} : rd_addr;

  fees_ram #(
    .WIDTH (fees_pkg::SITE_W),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_data.dir_x, in_data.dir_y, in_data.dir_z}),
    .rdata (ram_rdata)
  );

  // centre director and a shift line of neighbours; axis pass uses taps 0 and 1
  logic [fees_pkg::SITE_W-1:0] cen_r;
  logic [fees_pkg::SITE_W-1:0] nb_r [6];

  logic signed [DW-1:0] cc [3];
  logic signed [DW-1:0] pc [3];
  logic signed [DW-1:0] mc [3];

  for (genvar k = 0; k < 3; k++) begin : g_comp
    assign cc[k] = $signed(cen_r[DW*(3-k)-1 -: DW]);
    assign pc[k] = $signed(nb_r[0][DW*(3-k)-1 -: DW]);
    assign mc[k] = $signed(nb_r[1][DW*(3-k)-1 -: DW]);
  end

  // axis unit: dot products, weighted difference, gradient scaling
  logic signed [DOT_W-1:0] sp_dot_r, sm_dot_r;
  logic signed [DOT_W-1:0] sp_dot, sm_dot;
  logic signed [DQ_W-1:0]  dq_r [3];
  logic signed [DQ_W-1:0]  dq [3];
  logic signed [DN_W-1:0]  dn_new [3];
  logic signed [DN_W-1:0]  dn_r [3][3];
  logic signed [32:0]      grad_sel;

  always_comb begin
    logic signed [PD_W-1:0]  pa, pb;
    logic signed [DD_W-1:0]  dsum;
    logic signed [GP_W-1:0]  gp;
    sp_dot = '0;
    sm_dot = '0;
    for (int k = 0; k < 3; k++) begin
      sp_dot = sp_dot + DOT_W'(cc[k] * pc[k]);
      sm_dot = sm_dot + DOT_W'(cc[k] * mc[k]);
    end
    for (int k = 0; k < 3; k++) begin
      pa   = sp_dot_r * pc[k];
      pb   = sm_dot_r * mc[k];
      dsum = DD_W'(pa) - DD_W'(pb) + (DD_W'(1) <<< 21);
      dq[k] = $signed(dsum[DD_W-1:22]);
      gp   = dq_r[k] * grad_sel;
      gp   = gp + (GP_W'(1) <<< 19);
      dn_new[k] = $signed(gp[GP_W-1:20]);
    end
  end

  always_comb begin
    case (ax_r)
      AX_X:    grad_sel = $signed({1'b0, grad_x_r});
      AX_Y:    grad_sel = $signed({1'b0, grad_y_r});
      AX_Z:    grad_sel = z_end_r ? $signed({1'b0, grad_z_r, 1'b0})
                                  : $signed({2'b00, grad_z_r});
      default: grad_sel = '0;
    endcase
  end

  // curl, splay, twist and bend
  logic signed [CU_W-1:0]  a_r, b_r, e_r;
  logic signed [SP_W-1:0]  spl_r;
  logic signed [RAW_W-1:0] tw_raw_r, bd_raw_r [3];
  logic signed [RAW_W-1:0] tw_raw, bd_raw [3];
  logic signed [TW_W-1:0]  tw_r;
  logic signed [BD_W-1:0]  bd_r [3];
  logic signed [TW_W-1:0]  tw_rnd;
  logic signed [BD_W-1:0]  bd_rnd [3];

  always_comb begin
    logic signed [TP_W-1:0] c0a, c1b, c2e, c1e, c2b, c2a, c0e, c0b, c1a;
    logic signed [RAW_W-1:0] rs;
    c0a = cc[0] * a_r;
    c1b = cc[1] * b_r;
    c2e = cc[2] * e_r;
    c1e = cc[1] * e_r;
    c2b = cc[2] * b_r;
    c2a = cc[2] * a_r;
    c0e = cc[0] * e_r;
    c0b = cc[0] * b_r;
    c1a = cc[1] * a_r;
    tw_raw    = RAW_W'(c0a) + RAW_W'(c1b) + RAW_W'(c2e);
    bd_raw[0] = RAW_W'(c1e) - RAW_W'(c2b);
    bd_raw[1] = RAW_W'(c2a) - RAW_W'(c0e);
    bd_raw[2] = RAW_W'(c0b) - RAW_W'(c1a);
    rs     = tw_raw_r + (RAW_W'(1) <<< 13);
    tw_rnd = TW_W'($signed(rs[RAW_W-1:14])) - TW_W'(chirality_r);
    for (int k = 0; k < 3; k++) begin
      rs        = bd_raw_r[k] + (RAW_W'(1) <<< 13);
      bd_rnd[k] = $signed(rs[RAW_W-1:14]);
    end
  end

  // magnitudes and squares: lane 0 splay, 1 twist, 2..4 bend components
  logic [31:0] mag_r [5];
  logic        huge_r [5];
  logic [31:0] mag [5];
  logic        huge [5];
  logic [63:0] sq_r [5];

  always_comb begin
    logic signed [MG_W-1:0] v [5];
    logic [MG_W-1:0]        am;
    v[0] = MG_W'(spl_r);
    v[1] = MG_W'(tw_r);
    v[2] = MG_W'(bd_r[0]);
    v[3] = MG_W'(bd_r[1]);
    v[4] = MG_W'(bd_r[2]);
    for (int i = 0; i < 5; i++) begin
      am      = v[i][MG_W-1] ? MG_W'(-v[i]) : MG_W'(v[i]);
      mag[i]  = am[31:0];
      huge[i] = |am[MG_W-1:32];
    end
  end

  // weighting and saturation
  logic [63:0] esq_r [3];
  logic        ehuge_r [3];
  logic [63:0] ph_r [3];
  logic [63:0] pl_r [3];
  logic [31:0] wgt [3];
  logic [65:0] bsum;
  logic [EW-1:0] e_val [3];
  logic          e_sat [3];

  assign wgt[0] = splay_weight_r;
  assign wgt[1] = twist_weight_r;
  assign wgt[2] = bend_weight_r;
  assign bsum   = 66'(sq_r[2]) + 66'(sq_r[3]) + 66'(sq_r[4]);

  always_comb begin
    logic [64:0] lsum;
    logic [33:0] tsum;
    for (int i = 0; i < 3; i++) begin
      lsum = 65'(pl_r[i]) + (65'(1) << 31);
      tsum = 34'(ph_r[i][31:0]) + 34'(lsum[64:32]);
      if (wgt[i] == '0) begin
        e_val[i] = '0;
        e_sat[i] = 1'b0;
      end else if (ehuge_r[i] || (ph_r[i][63:32] != '0) || (tsum[33:32] != '0)) begin
        e_val[i] = '1;
        e_sat[i] = 1'b1;
      end else begin
        e_val[i] = tsum[31:0];
        e_sat[i] = 1'b0;
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ax_nxt        = ax_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.op == fees_pkg::OP_EVAL)) begin
          state_nxt = ST_READ;
          cnt_nxt   = RD_CEN;
          ax_nxt    = AX_X;
        end
      end
      ST_READ: begin
        cnt_nxt = 3'(cnt_r + 3'd1);
        if (cnt_r == RD_DONE) begin
          state_nxt = ST_DOT;
        end
      end
      ST_DOT: state_nxt = ST_DIF;
      ST_DIF: state_nxt = ST_GRD;
      ST_GRD: begin
        if (ax_r == AX_Z) begin
          state_nxt = ST_CRL;
        end else begin
          ax_nxt    = 2'(ax_r + 2'd1);
          state_nxt = ST_DOT;
        end
      end
      ST_CRL: state_nxt = ST_TWB;
      ST_TWB: state_nxt = ST_RND;
      ST_RND: state_nxt = ST_MAG;
      ST_MAG: state_nxt = ST_SQR;
      ST_SQR: state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_ENG;
      ST_ENG: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= RD_CEN;
      ax_r           <= AX_X;
      out_valid_r    <= 1'b0;
      grad_x_r       <= 32'd65536;
      grad_y_r       <= 32'd65536;
      grad_z_r       <= 31'd65536;
      chirality_r    <= '0;
      splay_weight_r <= '0;
      twist_weight_r <= '0;
      bend_weight_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fees_pkg::CFG_GRAD_X:       grad_x_r       <= cfg_data;
          fees_pkg::CFG_GRAD_Y:       grad_y_r       <= cfg_data;
          fees_pkg::CFG_GRAD_Z:       grad_z_r       <= cfg_data[30:0];
          fees_pkg::CFG_CHIRALITY:    chirality_r    <= $signed(cfg_data);
          fees_pkg::CFG_SPLAY_WEIGHT: splay_weight_r <= cfg_data;
          fees_pkg::CFG_TWIST_WEIGHT: twist_weight_r <= cfg_data;
          fees_pkg::CFG_BEND_WEIGHT:  bend_weight_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign cfg_ready = 1'b1;

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      xr_r    <= xin;
      yr_r    <= yin;
      zr_r    <= zin;
      z_end_r <= (zin == '0) || (zin == ZW'(SIZE_Z - 1));
    end
    // read data lags its slot: centre arrives with the x+ slot
    if ((state_r == ST_READ) && (cnt_r != RD_CEN)) begin
      if (cnt_r == RD_XP) begin
        cen_r <= ram_rdata;
      end else begin
        for (int i = 0; i < 5; i++) begin
          nb_r[i] <= nb_r[i+1];
        end
        nb_r[5] <= ram_rdata;
      end
    end
    if (state_r == ST_DOT) begin
      sp_dot_r <= sp_dot;
      sm_dot_r <= sm_dot;
    end
    if (state_r == ST_DIF) begin
      for (int k = 0; k < 3; k++) begin
        dq_r[k] <= dq[k];
      end
    end
    if (state_r == ST_GRD) begin
      for (int k = 0; k < 3; k++) begin
        case (ax_r)
          AX_X:    dn_r[0][k] <= dn_new[k];
          AX_Y:    dn_r[1][k] <= dn_new[k];
          AX_Z:    dn_r[2][k] <= dn_new[k];
          default: ;
        endcase
      end
      // next axis pair moves onto taps 0 and 1
      for (int i = 0; i < 4; i++) begin
        nb_r[i] <= nb_r[i+2];
      end
    end
    if (state_r == ST_CRL) begin
      a_r   <= CU_W'(dn_r[1][2]) - CU_W'(dn_r[2][1]);
      b_r   <= CU_W'(dn_r[2][0]) - CU_W'(dn_r[0][2]);
      e_r   <= CU_W'(dn_r[0][1]) - CU_W'(dn_r[1][0]);
      spl_r <= SP_W'(dn_r[0][0]) + SP_W'(dn_r[1][1]) + SP_W'(dn_r[2][2]);
    end
    if (state_r == ST_TWB) begin
      tw_raw_r <= tw_raw;
      for (int k = 0; k < 3; k++) begin
        bd_raw_r[k] <= bd_raw[k];
      end
    end
    if (state_r == ST_RND) begin
      tw_r <= tw_rnd;
      for (int k = 0; k < 3; k++) begin
        bd_r[k] <= bd_rnd[k];
      end
    end
    if (state_r == ST_MAG) begin
      for (int i = 0; i < 5; i++) begin
        mag_r[i]  <= mag[i];
        huge_r[i] <= huge[i];
      end
    end
    if (state_r == ST_SQR) begin
      for (int i = 0; i < 5; i++) begin
        sq_r[i] <= 64'(mag_r[i]) * 64'(mag_r[i]);
      end
    end
    if (state_r == ST_SUM) begin
      esq_r[0]   <= sq_r[0];
      ehuge_r[0] <= huge_r[0];
      esq_r[1]   <= sq_r[1];
      ehuge_r[1] <= huge_r[1];
      esq_r[2]   <= bsum[63:0];
      ehuge_r[2] <= huge_r[2] || huge_r[3] || huge_r[4] || (bsum[65:64] != '0);
    end
    if (state_r == ST_ENG) begin
      for (int i = 0; i < 3; i++) begin
        ph_r[i] <= 64'(wgt[i]) * 64'(esq_r[i][63:32]);
        pl_r[i] <= 64'(wgt[i]) * 64'(esq_r[i][31:0]);
      end
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_data.splay_energy <= e_val[0];
      out_data.twist_energy <= e_val[1];
      out_data.bend_energy  <= e_val[2];
      out_data.saturated    <= e_sat[0] || e_sat[1] || e_sat[2];
    end
  end

  assign out_valid = out_valid_r;

  // a new result only comes out of the last step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result word raised outside the final step");

  // the store is written only by a write word taken while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE) && (in_data.op == fees_pkg::OP_WRITE))
    else $error("store written outside an accepted write word");

  // curl step follows the z pass of the axis unit
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CRL) |-> ($past(state_r) == ST_GRD) && ($past(ax_r) == AX_Z))
    else $error("curl step entered before all three axes");

  // the saturated flag goes with an all-ones energy
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data.saturated) |->
      (out_data.splay_energy == '1) || (out_data.twist_energy == '1) ||
      (out_data.bend_energy == '1))
    else $error("saturated flag without a clipped energy");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of frank_elastic_energy_stencil_unit
// drives register and director writes and site evaluations, predicts every energy word and compares
`timescale 1ns / 1ps

module tb_top;

  typedef longint vec3_t [3];

  // register index that maps to no register
  localparam logic [fees_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fees_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fees_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fees_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fees_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state: lattice copy, written map and register copy
  logic [fees_pkg::SITE_W-1:0] lattice [32768];
  bit site_written [32768];
  logic [31:0] regs [7];

  fees_pkg::out_word_t energy_queue [$];
  int words_sent = 0;
  bit fail_seen = 1'b0;
  bit quiet_tail = 1'b0;
  int stall_left = 0;

  frank_elastic_energy_stencil_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("frank_elastic_energy_stencil_unit: mismatch");
    $finish;
  end

  function automatic int site_index(int x, int y, int z);
    return x + 32 * (y + 32 * z);
  endfunction

  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic vec3_t fetch_dir(int idx);
    vec3_t v;
    v[0] = longint'($signed(lattice[idx][47:32]));
    v[1] = longint'($signed(lattice[idx][31:16]));
    v[2] = longint'($signed(lattice[idx][15:0]));
    return v;
  endfunction

  // z neighbours: end planes use a one-sided pair
  function automatic void z_pair(int z, output int zp, output int zm);
    if (z == 0) begin
      zp = 1; zm = 0;
    end else if (z == 31) begin
      zp = 31; zm = 30;
    end else begin
      zp = z + 1; zm = z - 1;
    end
  endfunction

  function automatic bit stencil_ready(int x, int y, int z);
    int zp, zm;
    z_pair(z, zp, zm);
    return site_written[site_index(x, y, z)] &&
           site_written[site_index((x + 1) % 32, y, z)] &&
           site_written[site_index((x + 31) % 32, y, z)] &&
           site_written[site_index(x, (y + 1) % 32, z)] &&
           site_written[site_index(x, (y + 31) % 32, z)] &&
           site_written[site_index(x, y, zp)] && site_written[site_index(x, y, zm)];
  endfunction

  // neighbour-weighted difference along one axis, Q.16 per component
  function automatic vec3_t axis_slope(vec3_t c, vec3_t p, vec3_t m, longint g);
    vec3_t d;
    longint sp, sm;
    sp = c[0] * p[0] + c[1] * p[1] + c[2] * p[2];
    sm = c[0] * m[0] + c[1] * m[1] + c[2] * m[2];
    for (int k = 0; k < 3; k++)
      d[k] = round_shift(round_shift(sp * p[k] - sm * m[k], 22) * g, 20);
    return d;
  endfunction

  function automatic longint unsigned square_q16(longint v, ref bit huge);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    if (mag >= 64'd4294967296) begin
      huge = 1'b1;
      return 0;
    end
    return mag * mag;
  endfunction

  // {clipped, energy}
  function automatic logic [32:0] weighted_energy(longint unsigned sq, bit huge,
                                                  logic [31:0] w);
    longint unsigned t;
    if (w == 0) return 33'd0;
    if (huge) return {1'b1, 32'hFFFF_FFFF};
    t = longint'(w) * (sq >> 32);
    if (t < 64'd4294967296)
      t += (longint'(w) * (sq & 64'hFFFF_FFFF) + 64'd2147483648) >> 32;
    if (t >= 64'd4294967296) return {1'b1, 32'hFFFF_FFFF};
    return {1'b0, t[31:0]};
  endfunction

  function automatic fees_pkg::out_word_t site_energies(int x, int y, int z);
    vec3_t c, dx, dy, dz;
    int zp, zm;
    longint gz, a, b, e, sp, tw, chi;
    longint bd [3];
    bit hs, ht, hb;
    longint unsigned ssq, tsq, bsq, s;
    logic [32:0] es, et, eb;
    fees_pkg::out_word_t r;
    hs = 0; ht = 0; hb = 0; bsq = 0;
    c = fetch_dir(site_index(x, y, z));
    dx = axis_slope(c, fetch_dir(site_index((x + 1) % 32, y, z)),
                    fetch_dir(site_index((x + 31) % 32, y, z)),
                    longint'(regs[fees_pkg::CFG_GRAD_X]));
    dy = axis_slope(c, fetch_dir(site_index(x, (y + 1) % 32, z)),
                    fetch_dir(site_index(x, (y + 31) % 32, z)),
                    longint'(regs[fees_pkg::CFG_GRAD_Y]));
    z_pair(z, zp, zm);
    gz = longint'(regs[fees_pkg::CFG_GRAD_Z]);
    if (z == 0 || z == 31) gz = gz * 2;
    dz = axis_slope(c, fetch_dir(site_index(x, y, zp)),
                    fetch_dir(site_index(x, y, zm)), gz);
    a = dy[2] - dz[1];
    b = dz[0] - dx[2];
    e = dx[1] - dy[0];
    sp = dx[0] + dy[1] + dz[2];
    chi = longint'($signed(regs[fees_pkg::CFG_CHIRALITY]));
    tw = round_shift(c[0] * a + c[1] * b + c[2] * e, 14) - chi;
    bd[0] = round_shift(c[1] * e - c[2] * b, 14);
    bd[1] = round_shift(c[2] * a - c[0] * e, 14);
    bd[2] = round_shift(c[0] * b - c[1] * a, 14);
    ssq = square_q16(sp, hs);
    tsq = square_q16(tw, ht);
    for (int k = 0; k < 3; k++) begin
      s = square_q16(bd[k], hb);
      if (bsq + s < bsq) hb = 1'b1;
      bsq += s;
    end
    es = weighted_energy(ssq, hs, regs[fees_pkg::CFG_SPLAY_WEIGHT]);
    et = weighted_energy(tsq, ht, regs[fees_pkg::CFG_TWIST_WEIGHT]);
    eb = weighted_energy(bsq, hb, regs[fees_pkg::CFG_BEND_WEIGHT]);
    r.splay_energy = es[31:0];
    r.twist_energy = et[31:0];
    r.bend_energy = eb[31:0];
    r.saturated = es[32] | et[32] | eb[32];
    return r;
  endfunction

  // one word on the input channel; called at a falling edge
  task automatic send_word(input fees_pkg::in_word_t w);
    in_data = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (w.op == fees_pkg::OP_WRITE) begin
      lattice[site_index(w.site_x, w.site_y, w.site_z)] = {w.dir_x, w.dir_y, w.dir_z};
      site_written[site_index(w.site_x, w.site_y, w.site_z)] = 1'b1;
    end else begin
      energy_queue.push_back(site_energies(w.site_x, w.site_y, w.site_z));
    end
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic write_site(int x, int y, int z, logic [15:0] dx, logic [15:0] dy,
                            logic [15:0] dz);
    fees_pkg::in_word_t w;
    w.op = fees_pkg::OP_WRITE;
    w.site_x = 5'(x); w.site_y = 5'(y); w.site_z = 5'(z);
    w.dir_x = dx; w.dir_y = dy; w.dir_z = dz;
    send_word(w);
  endtask

  task automatic eval_site(int x, int y, int z);
    fees_pkg::in_word_t w;
    w = fees_pkg::in_word_t'({$urandom(), $urandom()});
    w.op = fees_pkg::OP_EVAL;
    w.site_x = 5'(x); w.site_y = 5'(y); w.site_z = 5'(z);
    send_word(w);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 4000) - 2000);
      1: return 16'($urandom_range(0, 32768) - 16384);
      default: return 16'($urandom());
    endcase
  endfunction

  // write the whole stencil around a centre with random directors
  task automatic write_stencil(int x, int y, int z);
    int zp, zm;
    z_pair(z, zp, zm);
    write_site(x, y, z, rand_comp(), rand_comp(), rand_comp());
    write_site((x + 1) % 32, y, z, rand_comp(), rand_comp(), rand_comp());
    write_site((x + 31) % 32, y, z, rand_comp(), rand_comp(), rand_comp());
    write_site(x, (y + 1) % 32, z, rand_comp(), rand_comp(), rand_comp());
    write_site(x, (y + 31) % 32, z, rand_comp(), rand_comp(), rand_comp());
    if (zp != z) write_site(x, y, zp, rand_comp(), rand_comp(), rand_comp());
    if (zm != z) write_site(x, y, zm, rand_comp(), rand_comp(), rand_comp());
  endtask

  // drain: drop in_valid, wait until no result word is still expected, then let the unit settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (energy_queue.size() != 0) @(negedge clk);
    repeat (32) @(negedge clk);
  endtask

  task automatic cfg_write(logic [fees_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == fees_pkg::CFG_GRAD_Z) regs[idx] = value & 32'h7FFF_FFFF;
    else if (idx <= fees_pkg::CFG_BEND_WEIGHT) regs[idx] = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic cfg_all(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                         logic [31:0] chi, logic [31:0] ws, logic [31:0] wt,
                         logic [31:0] wb);
    wait_idle();
    cfg_write(fees_pkg::CFG_GRAD_X, gx);
    cfg_write(fees_pkg::CFG_GRAD_Y, gy);
    cfg_write(fees_pkg::CFG_GRAD_Z, gz);
    cfg_write(fees_pkg::CFG_CHIRALITY, chi);
    cfg_write(fees_pkg::CFG_SPLAY_WEIGHT, ws);
    cfg_write(fees_pkg::CFG_TWIST_WEIGHT, wt);
    cfg_write(fees_pkg::CFG_BEND_WEIGHT, wb);
  endtask

  // reset values give zero weights: every energy reads zero
  task automatic test_reset_defaults();
    write_stencil(5, 6, 7);
    eval_site(5, 6, 7);
  endtask

  // extreme directors, wrap corners and both z end planes
  task automatic test_directed_extremes();
    cfg_all(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000,
            32'h0000_4000, 32'h0000_4000, 32'h0000_4000);
    write_site(0, 0, 0, 16'h7FFF, 16'h8000, 16'h0000);
    write_site(1, 0, 0, 16'h8000, 16'h7FFF, 16'h7FFF);
    write_site(31, 0, 0, 16'h4000, 16'h0000, 16'hC000);
    write_site(0, 1, 0, 16'hFFFF, 16'h0001, 16'h7FFF);
    write_site(0, 31, 0, 16'h0000, 16'h4000, 16'h8000);
    write_site(0, 0, 1, 16'h2D41, 16'hD2BF, 16'h0000);
    eval_site(0, 0, 0);
    write_stencil(31, 31, 31);
    eval_site(31, 31, 31);
    write_stencil(16, 31, 15);
    eval_site(16, 31, 15);
    // extreme registers: huge gradients and weights, most negative chirality, then a spare index write
    cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    cfg_write(CFG_SPARE_IDX, 32'hFFFF_FFFF);
    eval_site(0, 0, 0);
    eval_site(31, 31, 31);
    // zero gradients, max positive chirality, one zero weight
    cfg_all(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'h0001_0000);
    eval_site(16, 31, 15);
  endtask

  task automatic random_profile();
    logic [31:0] g [3];
    logic [31:0] wgt [3];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0: g[k] = 32'h0;
        1: g[k] = 32'hFFFF_FFFF;
        default: g[k] = $urandom_range(32'h2000, 32'h4_0000);
      endcase
      case ($urandom_range(0, 7))
        0: wgt[k] = 32'h0;
        1: wgt[k] = $urandom();
        default: wgt[k] = $urandom_range(1, 32'h2_0000);
      endcase
    end
    cfg_all(g[0], g[1], g[2],
            ($urandom_range(0, 3) == 0) ? $urandom()
              : 32'($urandom_range(0, 32'h4_0000) - 32'h2_0000),
            wgt[0], wgt[1], wgt[2]);
  endtask

  // mostly full stencils with evaluations, some noise writes and re-evaluations
  task automatic random_groups(int groups);
    int x, y, z, kind;
    x = 0; y = 0; z = 1;
    for (int n = 0; n < groups; n++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        x = $urandom_range(0, 31);
        y = $urandom_range(0, 31);
        case ($urandom_range(0, 3))
          0: z = 0;
          1: z = 31;
          default: z = $urandom_range(0, 31);
        endcase
        write_stencil(x, y, z);
        eval_site(x, y, z);
      end else if (kind == 7) begin
        if (stencil_ready(x, y, z)) begin
          write_site(x, (y + 1) % 32, z, rand_comp(), rand_comp(), rand_comp());
          eval_site(x, y, z);
        end
      end else if (kind == 8) begin
        write_site($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                   16'($urandom()), 16'($urandom()), 16'($urandom()));
      end else begin
        if (stencil_ready(x, y, z)) eval_site(x, y, z);
      end
    end
  endtask

  task automatic test_random();
    while (words_sent < 450) begin
      random_profile();
      random_groups(12);
    end
  endtask

  // last part runs with no idling on either side
  task automatic test_quiet_tail();
    quiet_tail = 1'b1;
    random_profile();
    random_groups(8);
  endtask

  // result side stalls in random bursts
  always @(negedge clk) begin
    if (quiet_tail || !rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each taken result word against the oldest prediction
  always @(posedge clk) begin
    fees_pkg::out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (energy_queue.size() == 0) begin
        $error("unexpected result word %h", out_data);
        fail_seen = 1'b1;
      end else begin
        exp_w = energy_queue.pop_front();
        if (out_data.splay_energy !== exp_w.splay_energy) begin
          $error("splay_energy exp %h got %h", exp_w.splay_energy, out_data.splay_energy);
          fail_seen = 1'b1;
        end
        if (out_data.twist_energy !== exp_w.twist_energy) begin
          $error("twist_energy exp %h got %h", exp_w.twist_energy, out_data.twist_energy);
          fail_seen = 1'b1;
        end
        if (out_data.bend_energy !== exp_w.bend_energy) begin
          $error("bend_energy exp %h got %h", exp_w.bend_energy, out_data.bend_energy);
          fail_seen = 1'b1;
        end
        if (out_data.saturated !== exp_w.saturated) begin
          $error("saturated exp %b got %b", exp_w.saturated, out_data.saturated);
          fail_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < 7; k++) regs[k] = 32'h0;
    regs[fees_pkg::CFG_GRAD_X] = 32'h0001_0000;
    regs[fees_pkg::CFG_GRAD_Y] = 32'h0001_0000;
    regs[fees_pkg::CFG_GRAD_Z] = 32'h0001_0000;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random();
    test_quiet_tail();
    in_valid = 1'b0;
    while (energy_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (!fail_seen && energy_queue.size() == 0)
      $display("frank_elastic_energy_stencil_unit: match");
    else
      $display("frank_elastic_energy_stencil_unit: mismatch");
    $finish;
  end

endmodule

// ===== frank_elastic_energy_stencil_unit.f =====
hdl/fees_pkg.sv
hdl/fees_ram.sv
hdl/frank_elastic_energy_stencil_unit.sv
tb/tb_top.sv
